// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_IMPL(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);

`endif

// ===== src/pts_pkg.sv =====
package pts_pkg;

  localparam int TIMER_SLOTS_DEF = 64;
  localparam int MAX_FIRES_DEF   = 32;

  localparam int ID_W    = 31;
  localparam int PER_W   = 31;
  localparam int DELAY_W = 31;
  localparam int NOW_W   = 63;
  localparam int DL_W    = 64;

  localparam int IN_DATA_W  = 160;
  localparam int OUT_DATA_W = 32;

  localparam logic [9:0]  US_PER_MS = 10'd1000;
  localparam logic [19:0] US_PER_S  = 20'd1000000;

  localparam logic [1:0] KIND_FIRED      = 2'd0;
  localparam logic [1:0] KIND_DONE       = 2'd1;
  localparam logic [1:0] KIND_REGISTERED = 2'd2;
  localparam logic [1:0] KIND_FULL       = 2'd3;

  localparam logic OP_REGISTER = 1'b0;
  localparam logic OP_TICK     = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [PER_W-1:0] period;
    logic [DL_W-1:0]  deadline;
  } slot_t;

endpackage

// ===== src/periodic_timer_scheduler_unit.sv =====
// A register command passes through ST_RMUL and then waits in ST_RWR for output room before its
// result word is loaded; a tick runs a linear scan of the slot memory (one entry read per cycle)
// before every firing and once more to close the tick.
// Throughput: one input word at a time; the next is taken once the last result is loaded.
// Reset (rst, synchronous): clears the active count, control state and output valid;
// slot memory contents are left as they are.
`include "assert_macros.svh"
module periodic_timer_scheduler_unit #(
  parameter int TIMER_SLOTS = pts_pkg::TIMER_SLOTS_DEF,
  parameter int MAX_FIRES_PER_TICK = pts_pkg::MAX_FIRES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // tdata: id[30:0], interval_ms[61:31], first_delay_s[92:62], now_us[155:93]
  input  logic [pts_pkg::IN_DATA_W-1:0]  s_tdata,
  // tuser: op
  input  logic                           s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // tdata: fired_id[30:0]
  output logic [pts_pkg::OUT_DATA_W-1:0] m_tdata,
  // tuser: kind
  output logic [1:0]                     m_tuser,
  output logic                           m_tlast
);
  import pts_pkg::*;

  localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CNT_W = $clog2(TIMER_SLOTS + 1);
  localparam int FIRE_W = $clog2(MAX_FIRES_PER_TICK + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RMUL = 3'd1;
  localparam logic [2:0] ST_RWR  = 3'd2;
  localparam logic [2:0] ST_SCAN = 3'd3;
  localparam logic [2:0] ST_FMUL = 3'd4;
  localparam logic [2:0] ST_FWR  = 3'd5;
  localparam logic [2:0] ST_RESP = 3'd6;

  // slot memory
  slot_t mem [TIMER_SLOTS];
  slot_t rd_data;
  logic  wr_en;
  logic [IDX_W-1:0] wr_addr, rd_addr;
  slot_t wr_data;

  logic [2:0] state;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] issue;
  logic [IDX_W-1:0] rd_slot;
  logic rd_pend;
  logic [FIRE_W-1:0] fires;
  logic [1:0] resp_kind;

  // latched input word
  logic [ID_W-1:0] in_id;
  logic [PER_W-1:0] in_per;
  logic [NOW_W-1:0] in_now;
  logic [DELAY_W-1:0] in_delay;
  logic [50:0] prod;

  // running minimum
  logic have_best;
  logic [IDX_W-1:0] best_slot;
  slot_t best;

  logic ofree;
  logic emit;
  assign ofree = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);

  // an output word is loaded this cycle
  assign emit = ofree && (state inside {ST_RWR, ST_FWR, ST_RESP});

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  assign rd_addr = issue[IDX_W-1:0];

  always_comb begin
    wr_en = 1'b0;
    wr_addr = best_slot;
    wr_data = best;
    if (state == ST_RWR && ofree) begin
      wr_en = 1'b1;
      wr_addr = count[IDX_W-1:0];
      wr_data.id = in_id;
      wr_data.period = (in_per == '0) ? PER_W'(1) : in_per;
      wr_data.deadline = {1'b0, in_now} + DL_W'(prod);
    end else if (state == ST_FWR && ofree) begin
      wr_en = 1'b1;
      wr_data.deadline = best.deadline + DL_W'(prod);
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      m_tvalid <= 1'b0;
      rd_pend <= 1'b0;
      issue <= '0;
      fires <= '0;
      have_best <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !emit) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            in_id <= s_tdata[30:0];
            in_per <= s_tdata[61:31];
            in_delay <= s_tdata[92:62];
            in_now <= s_tdata[155:93];
            issue <= '0;
            fires <= '0;
            have_best <= 1'b0;
            rd_pend <= 1'b0;
            if (s_tuser == OP_TICK) begin
              state <= ST_SCAN;
            end else if (count == CNT_W'(TIMER_SLOTS)) begin
              resp_kind <= KIND_FULL;
              state <= ST_RESP;
            end else begin
              state <= ST_RMUL;
            end
          end
        end
        ST_RMUL: begin
          prod <= 51'(in_delay) * 51'(US_PER_S);
          state <= ST_RWR;
        end
        ST_RWR: begin
          if (ofree) begin
            count <= count + CNT_W'(1);
            m_tvalid <= 1'b1;
            m_tuser <= KIND_REGISTERED;
            m_tdata <= '0;
            m_tlast <= 1'b1;
            state <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          rd_pend <= (issue < count);
          rd_slot <= issue[IDX_W-1:0];
          if (issue < count) issue <= issue + CNT_W'(1);
          if (rd_pend && (!have_best || rd_data.deadline < best.deadline)) begin
            have_best <= 1'b1;
            best <= rd_data;
            best_slot <= rd_slot;
          end
          if (!(issue < count) && !rd_pend) begin
            if (have_best && best.deadline < {1'b0, in_now}) begin
              state <= ST_FMUL;
            end else begin
              resp_kind <= KIND_DONE;
              state <= ST_RESP;
            end
          end
        end
        ST_FMUL: begin
          prod <= 51'(best.period * 41'(US_PER_MS));
          state <= ST_FWR;
        end
        ST_FWR: begin
          if (ofree) begin
            m_tvalid <= 1'b1;
            m_tuser <= KIND_FIRED;
            m_tdata <= {1'b0, best.id};
            m_tlast <= 1'b0;
            fires <= fires + FIRE_W'(1);
            issue <= '0;
            have_best <= 1'b0;
            rd_pend <= 1'b0;
            if (fires + FIRE_W'(1) == FIRE_W'(MAX_FIRES_PER_TICK)) begin
              resp_kind <= KIND_DONE;
              state <= ST_RESP;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_RESP: begin
          if (ofree) begin
            m_tvalid <= 1'b1;
            m_tuser <= resp_kind;
            m_tdata <= '0;
            m_tlast <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_fired_not_last, clk, rst, m_tvalid && m_tuser == KIND_FIRED, !m_tlast, "fired word marked last")
  `ASSERT_IMPL(a_count_range, clk, rst, 1'b1, count <= CNT_W'(TIMER_SLOTS), "active count over depth")
  `ASSERT_IMPL(a_fire_cap, clk, rst, 1'b1, fires <= FIRE_W'(MAX_FIRES_PER_TICK), "fire count over cap")
  `ASSERT_NEXT(a_reg_grows, clk, rst, state == ST_RWR && ofree, count == $past(count) + CNT_W'(1), "register did not take a slot")

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import pts_pkg::*;

  localparam int SLOTS     = 64;
  localparam int FIRE_CAP  = 32;
  localparam int LIMIT     = 4_000_000;
  localparam int RAND_ITEMS = 360;
  localparam logic [62:0] NOW_MAX = {63{1'b1}};
  localparam logic [63:0] FAR_BASE = 64'h4000_0000_0000_0000;

  typedef struct {
    logic        op;
    logic [30:0] ident;
    logic [30:0] interval_ms;
    logic [30:0] delay_s;
    logic [62:0] now_us;
    bit          drain_first;  // hold off until all results are back
  } timer_cmd_t;

  typedef struct {
    logic [1:0]  kind;
    logic [30:0] fired_id;
    logic        last;
  } sched_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [1:0] m_tuser;
  logic m_tlast;

  periodic_timer_scheduler_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  // Scheduler shadow state
  bit          shadow_used [SLOTS];
  logic [30:0] shadow_id [SLOTS];
  logic [30:0] shadow_period [SLOTS];
  logic [63:0] shadow_deadline [SLOTS];

  timer_cmd_t  pending_cmds[$];
  sched_word_t expected_words[$];
  timer_cmd_t  cur_cmd;
  int          cmds_taken = 0;
  int          errors = 0;
  int          cycles = 0;
  int          hold_cycles = 0;
  bit          hold_done = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Queue helpers
  task automatic add_word(input sched_word_t w);
    expected_words = {expected_words, w};
  endtask

  task automatic add_cmd(input timer_cmd_t c);
    pending_cmds = {pending_cmds, c};
  endtask

  // Work out the words one command produces and queue them
  task automatic predict_cmd(input timer_cmd_t c);
    int slot;
    int best;
    int fires;
    logic [30:0] per;
    sched_word_t w;
    begin
      if (c.op == OP_REGISTER) begin
        slot = -1;
        for (int i = 0; i < SLOTS; i++)
          if (slot < 0 && !shadow_used[i]) slot = i;
        w.fired_id = '0;
        w.last = 1'b1;
        if (slot < 0) begin
          w.kind = KIND_FULL;
        end else begin
          per = (c.interval_ms == 0) ? 31'd1 : c.interval_ms;
          shadow_used[slot] = 1'b1;
          shadow_id[slot] = c.ident;
          shadow_period[slot] = per;
          shadow_deadline[slot] = {1'b0, c.now_us} + 64'(c.delay_s) * 64'd1000000;
          w.kind = KIND_REGISTERED;
        end
        add_word(w);
      end else begin
        fires = 0;
        while (fires < FIRE_CAP) begin
          best = -1;
          for (int i = 0; i < SLOTS; i++)
            if (shadow_used[i] && (best < 0 || shadow_deadline[i] < shadow_deadline[best]))
              best = i;
          if (best < 0 || shadow_deadline[best] >= {1'b0, c.now_us}) break;
          w.kind = KIND_FIRED;
          w.fired_id = shadow_id[best];
          w.last = 1'b0;
          add_word(w);
          shadow_deadline[best] = shadow_deadline[best] + 64'(shadow_period[best]) * 64'd1000;
          fires++;
        end
        w.kind = KIND_DONE;
        w.fired_id = '0;
        w.last = 1'b1;
        add_word(w);
      end
    end
  endtask

  function automatic timer_cmd_t mk_cmd(logic op, logic [30:0] id, logic [30:0] per,
                                        logic [30:0] dly, logic [62:0] now);
    timer_cmd_t c;
    c.op = op; c.ident = id; c.interval_ms = per; c.delay_s = dly; c.now_us = now;
    c.drain_first = 1'b0;
    return c;
  endfunction

  // Idle percentages per phase
  function automatic int send_idle_pct();
    if (cmds_taken < 130) return 9;
    if (cmds_taken < 260) return 72;
    return 0;
  endfunction

  function automatic int recv_idle_pct();
    if (cmds_taken < 130) return 72;
    if (cmds_taken < 260) return 9;
    return 0;
  endfunction

  // Command driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_cmd(cur_cmd);
        cmds_taken <= cmds_taken + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_cmds.size() > 0
            && !(pending_cmds[0].drain_first && expected_words.size() > 0)
            && $urandom_range(0, 99) >= send_idle_pct()) begin
          cur_cmd = pending_cmds.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {4'b0, cur_cmd.now_us, cur_cmd.delay_s, cur_cmd.interval_ms,
                      cur_cmd.ident};
          s_tuser <= cur_cmd.op;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver back-pressure
  always @(posedge clk) begin
    sched_word_t exp_w;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word kind=%0d id=%0d last=%0d",
                   $time, m_tuser, m_tdata[30:0], m_tlast);
          errors++;
        end else begin
          exp_w = expected_words.pop_front();
          if (m_tuser !== exp_w.kind) begin
            $display("%0t: kind expected %0d actual %0d", $time, exp_w.kind, m_tuser);
            errors++;
          end
          if (m_tdata !== {1'b0, exp_w.fired_id}) begin
            $display("%0t: fired_id expected %0d actual %0d", $time, exp_w.fired_id, m_tdata);
            errors++;
          end
          if (m_tlast !== exp_w.last) begin
            $display("%0t: last expected %0d actual %0d", $time, exp_w.last, m_tlast);
            errors++;
          end
        end
      end
      // one long hold-off so the block backs up its input
      if (!hold_done && cmds_taken >= 100) begin
        hold_done <= 1'b1;
        hold_cycles <= 400;
        m_tready <= 1'b0;
      end else if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct());
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Stimulus and end of run
  initial begin
    logic [63:0] run_now;
    timer_cmd_t c;
    int pick;

    // directed: extremes, zero period, tie order, cap and leftovers
    add_cmd(mk_cmd(OP_TICK, 31'd0, 31'd0, 31'd0, 63'd0));
    add_cmd(mk_cmd(OP_REGISTER, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 63'd0));
    add_cmd(mk_cmd(OP_REGISTER, 31'd0, 31'd1, 31'd0, FAR_BASE[62:0]));
    add_cmd(mk_cmd(OP_REGISTER, 31'd5, 31'd0, 31'd0, FAR_BASE[62:0] + 63'd1000));
    add_cmd(mk_cmd(OP_REGISTER, 31'h2AAA_AAAA, 31'd3, 31'd0, FAR_BASE[62:0] + 63'd1000));
    add_cmd(mk_cmd(OP_TICK, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, FAR_BASE[62:0]));
    add_cmd(mk_cmd(OP_TICK, 31'd0, 31'd0, 31'd0, FAR_BASE[62:0] + 63'd1));
    add_cmd(mk_cmd(OP_TICK, 31'd0, 31'd0, 31'd0, FAR_BASE[62:0] + 63'd5000));
    add_cmd(mk_cmd(OP_TICK, 31'd0, 31'd0, 31'd0, FAR_BASE[62:0] + 63'd200000));
    add_cmd(mk_cmd(OP_TICK, 31'd0, 31'd0, 31'd0, FAR_BASE[62:0] + 63'd200000));
    add_cmd(mk_cmd(OP_TICK, 31'd0, 31'd0, 31'd0, FAR_BASE[62:0] + 63'd200000));
    add_cmd(mk_cmd(OP_REGISTER, 31'h5555_5555, 31'h4000_0000, 31'd0, NOW_MAX));
    add_cmd(mk_cmd(OP_TICK, 31'd0, 31'd0, 31'd0, NOW_MAX));
    add_cmd(mk_cmd(OP_REGISTER, 31'd9, 31'd2, 31'd1, 63'd0));
    add_cmd(mk_cmd(OP_REGISTER, 31'd10, 31'd2, 31'd1, 63'd0));
    add_cmd(mk_cmd(OP_TICK, 31'd0, 31'd0, 31'd0, 63'd1000000));
    add_cmd(mk_cmd(OP_TICK, 31'd0, 31'd0, 31'd0, 63'd1000001));
    add_cmd(mk_cmd(OP_TICK, 31'd0, 31'd0, 31'd0, 63'd1010000));

    // random: a running clock with mostly regular ticks
    run_now = 64'd1010000;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        c = mk_cmd(OP_REGISTER, 31'($urandom), 31'($urandom_range(1, 2000)),
                   31'($urandom_range(0, 3)), run_now[62:0]);
        if ($urandom_range(0, 9) == 0) c.interval_ms = 31'($urandom);
        if ($urandom_range(0, 9) == 0) c.interval_ms = 31'd0;
        if ($urandom_range(0, 19) == 0) c.delay_s = 31'($urandom);
      end else begin
        run_now = run_now + 64'($urandom_range(0, 200000));
        c = mk_cmd(OP_TICK, 31'($urandom), 31'($urandom), 31'($urandom), run_now[62:0]);
        if ($urandom_range(0, 29) == 0) c.now_us = 63'({$urandom, $urandom});
      end
      if (n == 60) c.drain_first = 1'b1;
      add_cmd(c);
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() > 0 || s_tvalid) @(posedge clk);
    while (expected_words.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
